// File: hdl/mdff_pkg.sv
// Shared types and constants of the 802.15.4 data frame filter.
package mdff_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned PLEN_W    = 7;
	localparam int unsigned CFG_IDX_W = 1;

	// Longest frame accepted; the length byte is compared against it.
	localparam logic [BYTE_W-1:0] MAX_FRAME_BYTES = 8'd127;
	localparam logic [BYTE_W-1:0] HEADER_BYTES    = 8'd11;

	localparam logic [ADDR_W-1:0] BROADCAST_ADDR = 16'hFFFF;
	localparam logic [ADDR_W-1:0] PAN_ID_RESET   = 16'd13;
	localparam logic [ADDR_W-1:0] NODE_ADDR_RESET = 16'd10000;

	// Frame control checks: data frame, PAN ID compression, short addresses.
	localparam logic [BYTE_W-1:0] FC0_MASK  = 8'h43;
	localparam logic [BYTE_W-1:0] FC0_MATCH = 8'h41;
	localparam logic [BYTE_W-1:0] FC1_MASK  = 8'hCC;
	localparam logic [BYTE_W-1:0] FC1_MATCH = 8'h88;

	// Byte positions inside the frame, counted from 1 after the length byte.
	localparam logic [BYTE_W-1:0] POS_FC0      = 8'd1;
	localparam logic [BYTE_W-1:0] POS_FC1      = 8'd2;
	localparam logic [BYTE_W-1:0] POS_SEQ      = 8'd3;
	localparam logic [BYTE_W-1:0] POS_PAN_LO   = 8'd4;
	localparam logic [BYTE_W-1:0] POS_PAN_HI   = 8'd5;
	localparam logic [BYTE_W-1:0] POS_DST_LO   = 8'd6;
	localparam logic [BYTE_W-1:0] POS_DST_HI   = 8'd7;
	localparam logic [BYTE_W-1:0] POS_SRC_LO   = 8'd8;
	localparam logic [BYTE_W-1:0] POS_SRC_HI   = 8'd9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAN_ID       = 1'b0,
		REG_NODE_ADDRESS = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_REJECT  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		WHY_SHORT  = 3'd0,
		WHY_FORMAT = 3'd1,
		WHY_PAN    = 3'd2,
		WHY_ADDR   = 3'd3,
		WHY_LONG   = 3'd4
	} reason_t;

	typedef struct packed {
		kind_t               kind;
		logic [BYTE_W-1:0]   payload_byte;
		logic [ADDR_W-1:0]   source_address;
		logic [ADDR_W-1:0]   dest_address;
		logic [BYTE_W-1:0]   sequence_res;
		logic [PLEN_W-1:0]   payload_length;
		reason_t             reject_reason;
		logic                last;
	} result_t;

endpackage

// File: hdl/mdff_if.sv
// Stream interfaces for received bytes and filter results.
interface mdff_byte_if;
	import mdff_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	logic              frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface mdff_result_if;
	import mdff_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [BYTE_W-1:0] payload_byte;
	logic [ADDR_W-1:0] source_address;
	logic [ADDR_W-1:0] dest_address;
	logic [BYTE_W-1:0] sequence_res;
	logic [PLEN_W-1:0] payload_length;
	logic [2:0]        reject_reason;
	logic              last;

	modport source (output valid, output kind, output payload_byte, output source_address,
		output dest_address, output sequence_res, output payload_length,
		output reject_reason, output last, input ready);
	modport sink   (input valid, input kind, input payload_byte, input source_address,
		input dest_address, input sequence_res, input payload_length,
		input reject_reason, input last, output ready);
endinterface

// File: hdl/mac_data_frame_filter_core.sv
// Top level of the 802.15.4 receive data frame filter.
// Each result beat is built combinationally and registered in the result buffer.
// Throughput: one byte beat per cycle while skid is free; a two-entry result
//   buffer keeps input flowing for one more result beat while results stall.
// Reset: arst_n clears the buffer, loads pan_id 13 and node_address 10000, and
//   idles the parser until a byte marked frame_start arrives.
module mac_data_frame_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_enable,
	input  logic [mdff_pkg::CFG_IDX_W-1:0] write_index,
	input  logic [mdff_pkg::ADDR_W-1:0]   write_data,
	mdff_byte_if.sink                     rx,
	mdff_result_if.source                 res
);
	import mdff_pkg::*;

	// Configuration registers
	logic [ADDR_W-1:0] pan_id_q;
	logic [ADDR_W-1:0] node_address_q;

	// Result buffer: main holds the beat on the port, skid catches one more
	result_t main_q, skid_q;
	logic    main_valid_q, skid_valid_q;

	logic    accept;
	logic    new_valid;
	result_t new_res;
	logic    pop;

	// Take a byte whenever the skid entry is free; one slot is always spare then.
	assign rx.ready = !skid_valid_q;
	assign accept   = rx.valid && rx.ready;
	assign pop      = main_valid_q && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_id_q       <= PAN_ID_RESET;
			node_address_q <= NODE_ADDR_RESET;
		end else if (write_enable) begin
			unique case (cfg_reg_t'(write_index))
				REG_PAN_ID:       pan_id_q       <= write_data;
				REG_NODE_ADDRESS: node_address_q <= write_data;
				default:          ;
			endcase
		end
	end

	// Parse the byte stream and build at most one result per byte
	mdff_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.rx_byte      (rx.rx_byte),
		.frame_start  (rx.frame_start),
		.pan_id       (pan_id_q),
		.node_address (node_address_q),
		.res_valid    (new_valid),
		.res          (new_res)
	);

	// Buffer control: advance skid into main on pop, else fill the free slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (accept && new_valid) begin
			if (main_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	// Payload of the buffer carries no reset
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (accept && new_valid) begin
			if (main_valid_q && !pop)
				skid_q <= new_res;
			else
				main_q <= new_res;
		end
	end

	// Drive the result beat
	assign res.valid          = main_valid_q;
	assign res.kind           = main_q.kind;
	assign res.payload_byte   = main_q.payload_byte;
	assign res.source_address = main_q.source_address;
	assign res.dest_address   = main_q.dest_address;
	assign res.sequence_res   = main_q.sequence_res;
	assign res.payload_length = main_q.payload_length;
	assign res.reject_reason  = main_q.reject_reason;
	assign res.last           = main_q.last;

endmodule

// File: hdl/mdff_parser.sv
// Frame parser: byte position tracking, header checks and result building.
module mdff_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [mdff_pkg::BYTE_W-1:0] rx_byte,
	input  logic                      frame_start,
	input  logic [mdff_pkg::ADDR_W-1:0] pan_id,
	input  logic [mdff_pkg::ADDR_W-1:0] node_address,
	output logic                      res_valid,
	output mdff_pkg::result_t         res
);
	import mdff_pkg::*;

	logic [BYTE_W-1:0] byte_position_q, byte_position_d;
	logic [BYTE_W-1:0] frame_length_q, frame_length_d;
	logic [BYTE_W-1:0] sequence_held_q, sequence_held_d;
	logic [BYTE_W-1:0] low_byte_held_q, low_byte_held_d;
	logic [ADDR_W-1:0] dest_held_q, dest_held_d;
	logic              discarding_q, discarding_d;

	logic [BYTE_W-1:0] pos;
	logic [ADDR_W-1:0] word;
	logic [BYTE_W:0]   pos_plus2;
	logic [BYTE_W:0]   len_ext;

	assign pos       = byte_position_q + 8'd1;
	assign word      = {rx_byte, low_byte_held_q};
	assign pos_plus2 = {1'b0, pos} + 9'd2;
	assign len_ext   = {1'b0, frame_length_q};

	always_comb begin
		byte_position_d = byte_position_q;
		frame_length_d  = frame_length_q;
		sequence_held_d = sequence_held_q;
		low_byte_held_d = low_byte_held_q;
		dest_held_d     = dest_held_q;
		discarding_d    = discarding_q;
		res_valid       = 1'b0;
		res             = '0;

		if (accept) begin
			if (frame_start) begin
				// A length byte always restarts, abandoning any frame in flight.
				byte_position_d = '0;
				frame_length_d  = rx_byte;
				discarding_d    = 1'b0;
				if (rx_byte < HEADER_BYTES) begin
					res_valid         = 1'b1;
					res.kind          = KIND_REJECT;
					res.reject_reason = WHY_SHORT;
					res.last          = 1'b1;
					discarding_d      = 1'b1;
				end else if (rx_byte > MAX_FRAME_BYTES) begin
					res_valid         = 1'b1;
					res.kind          = KIND_REJECT;
					res.reject_reason = WHY_LONG;
					res.last          = 1'b1;
					discarding_d      = 1'b1;
				end
			end else if (!discarding_q) begin
				byte_position_d = pos;
				if (pos >= frame_length_q)
					discarding_d = 1'b1;

				unique case (pos) inside
					POS_FC0: begin
						if ((rx_byte & FC0_MASK) != FC0_MATCH) begin
							res_valid         = 1'b1;
							res.kind          = KIND_REJECT;
							res.reject_reason = WHY_FORMAT;
							res.last          = 1'b1;
							discarding_d      = 1'b1;
						end
					end
					POS_FC1: begin
						if ((rx_byte & FC1_MASK) != FC1_MATCH) begin
							res_valid         = 1'b1;
							res.kind          = KIND_REJECT;
							res.reject_reason = WHY_FORMAT;
							res.last          = 1'b1;
							discarding_d      = 1'b1;
						end
					end
					POS_SEQ: begin
						sequence_held_d = rx_byte;
					end
					POS_PAN_LO, POS_DST_LO, POS_SRC_LO: begin
						low_byte_held_d = rx_byte;
					end
					POS_PAN_HI: begin
						if (word != pan_id) begin
							res_valid         = 1'b1;
							res.kind          = KIND_REJECT;
							res.reject_reason = WHY_PAN;
							res.last          = 1'b1;
							discarding_d      = 1'b1;
						end
					end
					POS_DST_HI: begin
						if (word != node_address && word != BROADCAST_ADDR) begin
							res_valid         = 1'b1;
							res.kind          = KIND_REJECT;
							res.reject_reason = WHY_ADDR;
							res.last          = 1'b1;
							discarding_d      = 1'b1;
						end else begin
							dest_held_d = word;
						end
					end
					POS_SRC_HI: begin
						res_valid          = 1'b1;
						res.kind           = KIND_HEADER;
						res.source_address = word;
						res.dest_address   = dest_held_q;
						res.sequence_res   = sequence_held_q;
						res.payload_length = PLEN_W'(frame_length_q - HEADER_BYTES);
						res.last           = (frame_length_q == HEADER_BYTES);
					end
					default: begin
						// Payload runs up to two bytes before the end; drop the FCS.
						if (pos_plus2 <= len_ext) begin
							res_valid        = 1'b1;
							res.kind         = KIND_PAYLOAD;
							res.payload_byte = rx_byte;
							res.last         = (pos_plus2 == len_ext);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			frame_length_q  <= '0;
			sequence_held_q <= '0;
			low_byte_held_q <= '0;
			dest_held_q     <= '0;
			discarding_q    <= 1'b1;
		end else begin
			byte_position_q <= byte_position_d;
			frame_length_q  <= frame_length_d;
			sequence_held_q <= sequence_held_d;
			low_byte_held_q <= low_byte_held_d;
			dest_held_q     <= dest_held_d;
			discarding_q    <= discarding_d;
		end
	end

endmodule
